[sv/spca_pkg.sv]
package spca_pkg;

  // Result field widths (fixed by the interface)
  localparam int SRV_W   = 4;
  localparam int DATA_W  = 16;
  localparam int DTIME_W = 18;
  localparam int SUM_W   = 5;

  // At most this many departures are reported per tick
  localparam int RES_MAX = 16;
  localparam int RES_W   = $clog2(RES_MAX + 1);

  // Configuration space
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_ACTIVE_SERVERS = 1'b0;
  localparam logic [SUM_W-1:0] ACTIVE_RESET = SUM_W'(1);

  // Request codes
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_ASSIGN = 1'b1;

  // Customer record held per server
  typedef struct packed {
    logic [DATA_W-1:0] customer;
    logic [DATA_W-1:0] arrival;
    logic [DATA_W-1:0] waiting;
    logic [DATA_W-1:0] ctime;
  } rec_t;

endpackage

[sv/server_pool_countdown_allocator_unit.sv]
// Assign, or tick with no departure: a countdown scan over the n servers in use, then one result
// (n = servers in use); the next transfer is taken once busy drops.
// Tick with departures: a countdown scan, then a departure scan that strobes each departed
// server in index order, one result per departure, before the next transfer is taken.
// busy drops with the last result strobe; the receiver cannot stall. Both scans share one read port.
// rst clears all servers to free and sets active_servers to 1; records need no clearing.
module server_pool_countdown_allocator_unit #(
  parameter int MAX_SERVERS = 16,
  parameter int TIME_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [spca_pkg::SRV_W-1:0]    server_index,
  input  logic [spca_pkg::DATA_W-1:0]   customer_number,
  input  logic [spca_pkg::DATA_W-1:0]   arrival_time,
  input  logic [spca_pkg::DATA_W-1:0]   waiting_time,
  input  logic [spca_pkg::DATA_W-1:0]   customer_time,
  input  logic [spca_pkg::DATA_W-1:0]   service_time,
  // result channel
  output logic                          result_strobe,
  output logic                          departed,
  output logic [spca_pkg::SRV_W-1:0]    departed_server,
  output logic [spca_pkg::DATA_W-1:0]   departed_customer,
  output logic [spca_pkg::DTIME_W-1:0]  departure_time,
  output logic signed [spca_pkg::SUM_W-1:0] first_free,
  output logic [spca_pkg::SUM_W-1:0]    busy_count,
  output logic                          bad_index,
  output logic                          last,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spca_pkg::PADDR_W-1:0]  paddr,
  input  logic [spca_pkg::PDATA_W-1:0]  pwdata,
  output logic [spca_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import spca_pkg::*;

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  state_t                 state;
  logic [SUM_W-1:0]       active_servers;
  logic [MAX_SERVERS-1:0] busy_mark;
  logic [MAX_SERVERS-1:0] dep_mark;
  logic [CNT_W-1:0]       rd_cnt;
  logic                   s1_valid;
  logic [IDX_W-1:0]       s1_idx;
  logic                   is_tick;
  logic                   bad_q;
  logic [CNT_W-1:0]       cnt;
  logic                   found;
  logic [IDX_W-1:0]       first_idx;
  logic [CNT_W-1:0]       dep_total;
  logic [RES_W-1:0]       emitted;

  // Record memories, one read port shared by both scans
  logic [TIME_WIDTH-1:0]  rem_mem [MAX_SERVERS];
  rec_t                   rec_mem [MAX_SERVERS];
  logic [TIME_WIDTH-1:0]  rem_q;
  rec_t                   rec_q;

  logic [CNT_W-1:0]       n;
  logic [IDX_W-1:0]       rd_addr;
  logic [IDX_W-1:0]       asg_addr;
  logic [31:0]            idx32;
  logic [31:0]            st32;
  logic [TIME_WIDTH-1:0]  st_load;
  logic                   idx_ok;
  logic                   accept;
  logic                   asg_wr;
  logic [TIME_WIDTH-1:0]  dec;
  logic                   s1_busy;
  logic                   s1_free_now;
  logic                   s1_busy_after;
  logic                   rem_wr;
  logic [IDX_W-1:0]       rem_wr_addr;
  logic [TIME_WIDTH-1:0]  rem_wr_data;
  logic                   issue;
  logic [31:0]            limit;
  logic [31:0]            first32;
  logic [31:0]            cnt32;
  logic [SUM_W-1:0]       ff_val;
  logic [SUM_W-1:0]       bc_val;
  logic [31:0]            s1_idx32;
  logic                   cfg_wr;

  // Servers in use, clipped to the pool size
  assign n = (32'(active_servers) > 32'(MAX_SERVERS)) ? CNT_W'(MAX_SERVERS)
                                                       : CNT_W'(active_servers);

  assign busy    = (state != ST_IDLE);
  assign accept  = start && (state == ST_IDLE);
  assign idx32   = 32'(server_index);
  assign asg_addr = idx32[IDX_W-1:0];
  assign idx_ok  = (idx32 < 32'(n));
  assign asg_wr  = accept && (req_type == REQ_ASSIGN) && idx_ok;

  // Service time masked to the countdown width, zero loads as one
  assign st32    = 32'(service_time);
  assign st_load = (st32[TIME_WIDTH-1:0] == '0) ? TIME_WIDTH'(1) : st32[TIME_WIDTH-1:0];

  // Countdown stage of the scan
  assign dec           = rem_q - TIME_WIDTH'(1);
  assign s1_busy       = busy_mark[s1_idx];
  assign s1_free_now   = s1_busy && is_tick && (dec == '0);
  assign s1_busy_after = s1_busy && !s1_free_now;

  assign rd_addr = rd_cnt[IDX_W-1:0];
  assign issue   = (rd_cnt < n);

  // Countdown write port: load on assign, decrement during the tick scan
  assign rem_wr      = asg_wr || ((state == ST_SCAN) && s1_valid && s1_busy && is_tick);
  assign rem_wr_addr = asg_wr ? asg_addr : s1_idx;
  assign rem_wr_data = asg_wr ? st_load : dec;

  // Step summary from the scan accumulators
  assign first32 = 32'(first_idx);
  assign cnt32   = 32'(cnt);
  assign ff_val  = found ? first32[SUM_W-1:0] : '1;
  assign bc_val  = cnt32[SUM_W-1:0];
  assign limit   = (32'(dep_total) > 32'(RES_MAX)) ? 32'(RES_MAX) : 32'(dep_total);
  assign s1_idx32 = 32'(s1_idx);

  always_ff @(posedge clk) begin
    if (rem_wr) begin
      rem_mem[rem_wr_addr] <= rem_wr_data;
    end
    rem_q <= rem_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (asg_wr) begin
      rec_mem[asg_addr] <= '{customer: customer_number, arrival: arrival_time,
                             waiting: waiting_time, ctime: customer_time};
    end
    rec_q <= rec_mem[rd_addr];
  end

  // Configuration register
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[PADDR_W-1:2] == REG_ACTIVE_SERVERS);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_ACTIVE_SERVERS) ? PDATA_W'(active_servers)
                                                             : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_servers <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      active_servers <= pwdata[SUM_W-1:0];
    end
  end

  // Sequencer: accept, countdown scan, departure scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      busy_mark     <= '0;
      dep_mark      <= '0;
      rd_cnt        <= '0;
      s1_valid      <= 1'b0;
      s1_idx        <= '0;
      is_tick       <= 1'b0;
      bad_q         <= 1'b0;
      cnt           <= '0;
      found         <= 1'b0;
      first_idx     <= '0;
      dep_total     <= '0;
      emitted       <= '0;
      result_strobe <= 1'b0;
      departed      <= 1'b0;
      departed_server   <= '0;
      departed_customer <= '0;
      departure_time    <= '0;
      first_free    <= '0;
      busy_count    <= '0;
      bad_index     <= 1'b0;
      last          <= 1'b0;
    end else begin
      result_strobe <= 1'b0;

      // shared read issue for both scans
      if (state != ST_IDLE) begin
        if (issue) begin
          rd_cnt   <= rd_cnt + CNT_W'(1);
          s1_valid <= 1'b1;
          s1_idx   <= rd_addr;
        end else begin
          s1_valid <= 1'b0;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            is_tick   <= (req_type == REQ_TICK);
            bad_q     <= (req_type == REQ_ASSIGN) && !idx_ok;
            if (asg_wr) begin
              busy_mark[asg_addr] <= 1'b1;
            end
            dep_mark  <= '0;
            dep_total <= '0;
            cnt       <= '0;
            found     <= 1'b0;
            emitted   <= '0;
            rd_cnt    <= '0;
            s1_valid  <= 1'b0;
            state     <= ST_SCAN;
          end
        end

        ST_SCAN: begin
          if (s1_valid) begin
            if (s1_free_now) begin
              busy_mark[s1_idx] <= 1'b0;
              dep_mark[s1_idx]  <= 1'b1;
              dep_total         <= dep_total + CNT_W'(1);
            end
            if (s1_busy_after) begin
              cnt <= cnt + CNT_W'(1);
            end else if (!found) begin
              found     <= 1'b1;
              first_idx <= s1_idx;
            end
          end else if (!issue) begin
            // scan finished: summary known
            if (!is_tick || (dep_total == '0)) begin
              result_strobe     <= 1'b1;
              departed          <= 1'b0;
              departed_server   <= '0;
              departed_customer <= '0;
              departure_time    <= '0;
              first_free        <= ff_val;
              busy_count        <= bc_val;
              bad_index         <= bad_q;
              last              <= 1'b1;
              state             <= ST_IDLE;
            end else begin
              // s1_valid is already cleared by the issue logic
              rd_cnt   <= '0;
              state    <= ST_EMIT;
            end
          end
        end

        ST_EMIT: begin
          // one departure transfer per marked server, lowest index first
          if (s1_valid && dep_mark[s1_idx]) begin
            result_strobe     <= 1'b1;
            departed          <= 1'b1;
            departed_server   <= s1_idx32[SRV_W-1:0];
            departed_customer <= rec_q.customer;
            departure_time    <= DTIME_W'(rec_q.arrival) + DTIME_W'(rec_q.waiting)
                                 + DTIME_W'(rec_q.ctime);
            first_free        <= ff_val;
            busy_count        <= bc_val;
            bad_index         <= 1'b0;
            emitted           <= emitted + RES_W'(1);
            if ((32'(emitted) + 32'd1) == limit) begin
              last  <= 1'b1;
              state <= ST_IDLE;
            end else begin
              last  <= 1'b0;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
